/* sv/rrp_pkg.sv */
package rrp_pkg;

   // Flag and opcode values of the drive's packet protocol
   localparam logic [7:0] FLAG_NULL   = 8'h00;
   localparam logic [7:0] FLAG_DATA   = 8'h01;
   localparam logic [7:0] FLAG_CTRL   = 8'h02;
   localparam logic [7:0] FLAG_CONT   = 8'h10;
   localparam logic [7:0] CTRL_LENGTH = 8'd10;
   localparam logic [7:0] OPCODE_END  = 8'h40;

   localparam logic [7:0] END_FILLER_BYTES = 8'd8;

   localparam logic [15:0] REQUESTED_BYTES_RESET = 16'd512;

   // Completion status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_DATA_CKSUM  = 3'd1;
   localparam logic [2:0] STATUS_BAD_FLAG    = 3'd2;
   localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd3;
   localparam logic [2:0] STATUS_NOT_END     = 3'd4;
   localparam logic [2:0] STATUS_END_CKSUM   = 3'd5;

   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD_DATA,
      SUM_LOAD_END,
      SUM_ADD
   } sum_op_type;

   typedef struct packed {
      sum_op_type op;
      logic [7:0] rx_byte;
   } sum_ctl_type;

   typedef struct packed {
      logic [15:0] sum;
      logic        last;
   } sum_sts_type;

   // End-around carry: add bit 16 back into the low 16 bits
   function automatic logic [16:0] fold(input logic [16:0] s);
      fold = {1'b0, s[15:0]} + {16'd0, s[16]};
   endfunction

endpackage

/* sv/rrp_checksum.sv */
module rrp_checksum (
   input  logic                 clock,
   input  logic                 reset,
   input  rrp_pkg::sum_ctl_type ctl,
   output rrp_pkg::sum_sts_type sts
);
   import rrp_pkg::*;

   logic [16:0] sum_acc_ff, sum_acc_in;
   logic        odd_position_ff, odd_position_in;
   logic [7:0]  packet_left_ff, packet_left_in;
   logic [17:0] add_wide;
   logic [16:0] add_sum;
   logic        last;

   assign last = (packet_left_ff <= 8'd1);

   always_comb begin
      if (odd_position_ff) begin
         add_wide = {1'b0, sum_acc_ff} + {2'b00, ctl.rx_byte, 8'd0};
      end else begin
         add_wide = {1'b0, sum_acc_ff} + {10'd0, ctl.rx_byte};
      end
      add_sum = add_wide[16:0];
      if (odd_position_ff || last) begin
         add_sum = fold(add_sum);
      end
   end

   always_comb begin
      sum_acc_in      = sum_acc_ff;
      odd_position_in = odd_position_ff;
      packet_left_in  = packet_left_ff;
      case (ctl.op)
         SUM_LOAD_DATA: begin
            sum_acc_in      = {1'b0, ctl.rx_byte, FLAG_DATA};
            odd_position_in = 1'b0;
            packet_left_in  = ctl.rx_byte;
         end
         SUM_LOAD_END: begin
            sum_acc_in      = fold({1'b0, CTRL_LENGTH, FLAG_CTRL}
                                   + {1'b0, ctl.rx_byte, OPCODE_END});
            odd_position_in = 1'b0;
            packet_left_in  = END_FILLER_BYTES;
         end
         SUM_ADD: begin
            sum_acc_in      = add_sum;
            odd_position_in = ~odd_position_ff;
            if (packet_left_ff != 8'd0) begin
               packet_left_in = packet_left_ff - 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_acc_ff      <= '0;
         odd_position_ff <= 1'b0;
         packet_left_ff  <= '0;
      end else begin
         sum_acc_ff      <= sum_acc_in;
         odd_position_ff <= odd_position_in;
         packet_left_ff  <= packet_left_in;
      end
   end

   assign sts.sum  = sum_acc_ff[15:0];
   assign sts.last = last;

endmodule

/* sv/rsp_read_response_parser.sv */
// Read-response parser: takes the byte stream a tape drive returns after a read
// command, checks data and end packets with a 16-bit end-around-carry sum, passes
// on the first requested_bytes payload bytes of each transfer as data results and
// closes every transfer with one final result carrying status and drive code.
// One byte can be taken every clock cycle; the input stalls only while a result
// waits on a stalled receiver. A byte sits in the input register until it is
// processed, which a stalled receiver can delay; its result, if any, is then
// presented by the result register. requested_bytes is sampled on the first
// byte of each transfer.
module rsp_read_response_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_final,
   output logic [7:0]        rsp_data_byte,
   output logic [2:0]        rsp_status,
   output logic signed [7:0] rsp_drive_code,
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data
);
   import rrp_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_END_WAIT,
      PH_DLEN,
      PH_DPAY,
      PH_DCK0,
      PH_DCK1,
      PH_ELEN,
      PH_EOP,
      PH_ESUCC,
      PH_EFILL,
      PH_ECK0,
      PH_ECK1
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [15:0]       requested_bytes_ff;
   logic              req_valid_ff;
   logic [7:0]        req_byte_ff;
   logic [15:0]       budget_left_ff, budget_left_in, budget_cur;
   logic              budget_loaded_ff, budget_loaded_in;
   logic [7:0]        held_code_ff, held_code_in;
   logic [7:0]        sum_low_byte_ff, sum_low_byte_in;
   logic              rsp_valid_ff;
   logic              rsp_is_final_ff, rsp_is_final_in;
   logic [7:0]        rsp_data_byte_ff, rsp_data_byte_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic signed [7:0] rsp_drive_code_ff, rsp_drive_code_in;
   logic              emit;
   logic              advance;
   logic              process;
   sum_ctl_type       sum_ctl;
   sum_sts_type       sum_sts;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   assign budget_cur = budget_loaded_ff ? budget_left_ff : requested_bytes_ff;

   rrp_checksum u_checksum (
      .clock (clock),
      .reset (reset),
      .ctl   (sum_ctl),
      .sts   (sum_sts)
   );

   always_comb begin
      phase_in          = phase_ff;
      budget_left_in    = budget_cur;
      budget_loaded_in  = 1'b1;
      held_code_in      = held_code_ff;
      sum_low_byte_in   = sum_low_byte_ff;
      emit              = 1'b0;
      rsp_is_final_in   = 1'b1;
      rsp_data_byte_in  = 8'd0;
      rsp_status_in     = STATUS_OK;
      rsp_drive_code_in = 8'sd0;
      sum_ctl.op        = SUM_HOLD;
      sum_ctl.rx_byte   = req_byte_ff;

      case (phase_ff)
         PH_IDLE: begin
            case (req_byte_ff)
               FLAG_DATA: phase_in = PH_DLEN;
               FLAG_CONT: phase_in = PH_IDLE;
               FLAG_NULL: phase_in = PH_END_WAIT;
               FLAG_CTRL: phase_in = PH_ELEN;
               default: begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_BAD_FLAG;
               end
            endcase
         end
         PH_END_WAIT: begin
            if (req_byte_ff == FLAG_CTRL) begin
               phase_in = PH_ELEN;
            end else if (req_byte_ff != FLAG_NULL && req_byte_ff != FLAG_CONT) begin
               emit          = 1'b1;
               rsp_status_in = STATUS_BAD_FLAG;
            end
         end
         PH_DLEN: begin
            sum_ctl.op = SUM_LOAD_DATA;
            phase_in   = (req_byte_ff == 8'd0) ? PH_DCK0 : PH_DPAY;
         end
         PH_DPAY: begin
            sum_ctl.op = SUM_ADD;
            if (sum_sts.last) begin
               phase_in = PH_DCK0;
            end
            if (budget_cur != 16'd0) begin
               budget_left_in   = budget_cur - 16'd1;
               emit             = 1'b1;
               rsp_is_final_in  = 1'b0;
               rsp_data_byte_in = req_byte_ff;
            end
         end
         PH_DCK0: begin
            sum_low_byte_in = req_byte_ff;
            phase_in        = PH_DCK1;
         end
         PH_DCK1: begin
            if ({req_byte_ff, sum_low_byte_ff} != sum_sts.sum) begin
               emit          = 1'b1;
               rsp_status_in = STATUS_DATA_CKSUM;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_ELEN: begin
            if (req_byte_ff != CTRL_LENGTH) begin
               emit          = 1'b1;
               rsp_status_in = STATUS_BAD_LENGTH;
            end else begin
               phase_in = PH_EOP;
            end
         end
         PH_EOP: begin
            if (req_byte_ff != OPCODE_END) begin
               emit          = 1'b1;
               rsp_status_in = STATUS_NOT_END;
            end else begin
               phase_in = PH_ESUCC;
            end
         end
         PH_ESUCC: begin
            held_code_in = req_byte_ff;
            sum_ctl.op   = SUM_LOAD_END;
            phase_in     = (END_FILLER_BYTES == 8'd0) ? PH_ECK0 : PH_EFILL;
         end
         PH_EFILL: begin
            sum_ctl.op = SUM_ADD;
            if (sum_sts.last) begin
               phase_in = PH_ECK0;
            end
         end
         PH_ECK0: begin
            sum_low_byte_in = req_byte_ff;
            phase_in        = PH_ECK1;
         end
         PH_ECK1: begin
            emit = 1'b1;
            if ({req_byte_ff, sum_low_byte_ff} != sum_sts.sum) begin
               rsp_status_in = STATUS_END_CKSUM;
            end else begin
               rsp_drive_code_in = signed'(held_code_ff);
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // a final result ends the transfer: back to start, reload budget next time
      if (emit && rsp_is_final_in) begin
         phase_in         = PH_IDLE;
         budget_loaded_in = 1'b0;
      end

      if (!process) begin
         sum_ctl.op = SUM_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         requested_bytes_ff <= REQUESTED_BYTES_RESET;
         req_valid_ff       <= 1'b0;
         budget_left_ff     <= '0;
         budget_loaded_ff   <= 1'b0;
         held_code_ff       <= '0;
         sum_low_byte_ff    <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            requested_bytes_ff <= csr_write_data;
         end
         // hold the input register while the result side is stalled
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (process) begin
            phase_ff         <= phase_in;
            budget_left_ff   <= budget_left_in;
            budget_loaded_ff <= budget_loaded_in;
            held_code_ff     <= held_code_in;
            sum_low_byte_ff  <= sum_low_byte_in;
         end
         if (process && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (advance) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_byte_ff <= req_rx_byte;
      end
      if (process && emit) begin
         rsp_is_final_ff   <= rsp_is_final_in;
         rsp_data_byte_ff  <= rsp_data_byte_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_drive_code_ff <= rsp_drive_code_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_final   = rsp_is_final_ff;
   assign rsp_data_byte  = rsp_data_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_drive_code = rsp_drive_code_ff;

endmodule
